// ----- hw/rtl/nearest_breakpoint_resolver_macros.svh -----
// assertion helpers used by the checker file
`ifndef NEAREST_BREAKPOINT_RESOLVER_MACROS_SVH
`define NEAREST_BREAKPOINT_RESOLVER_MACROS_SVH

// same-cycle implication, held off during reset
`define NBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbr check failed");

// next-cycle implication, held off during reset
`define NBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbr check failed");

`endif

// ----- hw/rtl/nbr_pkg.sv -----
`timescale 1ns / 1ps

package nbr_pkg;

  localparam int unsigned MAX_RECORDS_DEF   = 256;
  localparam int unsigned MAX_BREAKABLE_DEF = 256;
  localparam int unsigned SLOT_DEPTH        = 256;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LINE_W     = 16;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  // line distance weight; 65535 * 10000 + 65535 fits in 30 bits
  localparam int unsigned LINE_WEIGHT = 10000;
  localparam int unsigned SCORE_W     = 30;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_REC = 2'd0,
    CMD_WR_BRK = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_COUNT    = 1'b0,
    REG_BREAKABLE_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRK_WAIT,
    ST_SEARCH,
    ST_REC_WAIT,
    ST_EVAL,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ----- hw/rtl/nbr_if.sv -----
`timescale 1ns / 1ps

interface nbr_in_if;
  logic                       valid;
  logic                       ready;
  logic [nbr_pkg::CMD_W-1:0]  cmd;
  logic [nbr_pkg::SLOT_W-1:0] slot;
  logic [nbr_pkg::ADDR_W-1:0] code_address;
  logic [nbr_pkg::LINE_W-1:0] src_line;
  logic [nbr_pkg::COL_W-1:0]  src_col;

  modport source (output valid, cmd, slot, code_address, src_line, src_col, input ready);
  modport sink   (input valid, cmd, slot, code_address, src_line, src_col, output ready);
endinterface

interface nbr_out_if;
  logic                       valid;
  logic                       ready;
  logic [nbr_pkg::ADDR_W-1:0] best_address;
  logic                       matched;

  modport source (output valid, best_address, matched, input ready);
  modport sink   (input valid, best_address, matched, output ready);
endinterface

// ----- hw/rtl/nbr_ram.sv -----
`timescale 1ns / 1ps

module nbr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/nearest_breakpoint_resolver.sv -----
`timescale 1ns / 1ps

// channel  dir  payload                                      handshake
// in_i     in   cmd, slot, code_address, src_line, src_col   valid/ready
// out_o    out  best_address, matched                        valid/ready
// cfg      in   cfg_idx_i, cfg_data_i                        cfg_we_i
//
// record and breakable writes leave the block idle and ready
// a query steps through the breakable entries in turn; for each one, the binary
// search steps through the record memory over its single read port, one probe
// per cycle
// rst_ni clears the counts and the control; memory contents are not cleared
// a result waits in the output register; writes go on, a further query runs but waits at its end for it

module nearest_breakpoint_resolver #(
  parameter int unsigned MAX_RECORDS   = nbr_pkg::MAX_RECORDS_DEF,
  parameter int unsigned MAX_BREAKABLE = nbr_pkg::MAX_BREAKABLE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nbr_in_if.sink                         in_i,
  nbr_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [nbr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nbr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CNT_W    = nbr_pkg::CNT_W;
  localparam int unsigned TAB_DEPTH =
      (MAX_RECORDS < nbr_pkg::SLOT_DEPTH) ? MAX_RECORDS : nbr_pkg::SLOT_DEPTH;
  localparam int unsigned BRK_DEPTH =
      (MAX_BREAKABLE < nbr_pkg::SLOT_DEPTH) ? MAX_BREAKABLE : nbr_pkg::SLOT_DEPTH;
  localparam int unsigned REC_AW = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int unsigned BRK_AW = (BRK_DEPTH > 1) ? $clog2(BRK_DEPTH) : 1;

  nbr_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] rec_cnt_q, brk_cnt_q;
  logic [CNT_W-1:0] rec_lim, brk_lim;

  logic [CNT_W-1:0]            i_q, i_d;
  logic [CNT_W-1:0]            lo_q, lo_d;
  logic [CNT_W-1:0]            hip1_q, hip1_d;
  logic [CNT_W-1:0]            mid_q, mid_d;
  logic [nbr_pkg::ADDR_W-1:0]  ip_q, ip_d;
  logic [nbr_pkg::LINE_W-1:0]  qline_q, qline_d;
  logic [nbr_pkg::COL_W-1:0]   qcol_q, qcol_d;
  logic [nbr_pkg::LINE_W-1:0]  rline_q, rline_d;
  logic [nbr_pkg::COL_W-1:0]   rcol_q, rcol_d;
  logic                        cand_q, cand_d;
  logic [nbr_pkg::SCORE_W-1:0] score_q, score_d;
  logic [nbr_pkg::SCORE_W-1:0] best_score_q, best_score_d;
  logic [nbr_pkg::ADDR_W-1:0]  best_q, best_d;
  logic                        found_q, found_d;

  logic                        out_valid_q, out_valid_d;
  logic [nbr_pkg::ADDR_W-1:0]  out_best_q, out_best_d;
  logic                        out_matched_q, out_matched_d;

  // memory ports
  logic                       rec_we, rec_re;
  logic [REC_AW-1:0]          rec_waddr, rec_raddr;
  nbr_pkg::rec_t              rec_wdata, rec_rdata;
  logic                       brk_we, brk_re;
  logic [BRK_AW-1:0]          brk_waddr, brk_raddr;
  logic [nbr_pkg::ADDR_W-1:0] brk_rdata;

  logic            in_fire, slot_rec_ok, slot_brk_ok, out_load;
  nbr_pkg::cmd_e   in_cmd;

  // binary search step on the probed record
  logic             cmp_eq, cmp_lt, search_go;
  logic [CNT_W-1:0] lo_nx, hip1_nx, mid_nx, mid_init, lo_m1, rec_lim_m1, i_nx;
  logic [CNT_W:0]   mid_sum;

  // scoring
  logic                        at_or_after;
  logic [nbr_pkg::LINE_W-1:0]  dl;
  logic [nbr_pkg::COL_W-1:0]   dc;
  logic [nbr_pkg::SCORE_W-1:0] score_calc;
  logic                        better;

  assign in_cmd     = nbr_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = (state_q == nbr_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign rec_lim = (rec_cnt_q > CNT_W'(TAB_DEPTH)) ? CNT_W'(TAB_DEPTH) : rec_cnt_q;
  assign brk_lim = (brk_cnt_q > CNT_W'(BRK_DEPTH)) ? CNT_W'(BRK_DEPTH) : brk_cnt_q;

  assign slot_rec_ok = ({1'b0, in_i.slot} < CNT_W'(TAB_DEPTH));
  assign slot_brk_ok = ({1'b0, in_i.slot} < CNT_W'(BRK_DEPTH));

  assign cmp_eq    = (rec_rdata.addr == ip_q);
  assign cmp_lt    = (rec_rdata.addr < ip_q);
  assign lo_nx     = cmp_lt ? (mid_q + CNT_W'(1)) : lo_q;
  assign hip1_nx   = cmp_lt ? hip1_q : mid_q;
  assign mid_sum   = {1'b0, lo_nx} + {1'b0, hip1_nx} - (CNT_W+1)'(1);
  assign mid_nx    = mid_sum[CNT_W:1];
  assign search_go = (lo_nx < hip1_nx);
  assign lo_m1     = lo_nx - CNT_W'(1);
  assign rec_lim_m1 = rec_lim - CNT_W'(1);
  assign mid_init  = {1'b0, rec_lim_m1[CNT_W-1:1]};
  assign i_nx      = i_q + CNT_W'(1);

  assign at_or_after = (rline_q > qline_q) || ((rline_q == qline_q) && (rcol_q >= qcol_q));
  assign dl          = rline_q - qline_q;
  assign dc          = rcol_q - qcol_q;
  assign score_calc  = (dl == '0) ? nbr_pkg::SCORE_W'(dc)
                     : nbr_pkg::SCORE_W'(dl) * nbr_pkg::SCORE_W'(nbr_pkg::LINE_WEIGHT);
  assign better      = cand_q && (!found_q || (score_q < best_score_q));

  assign out_load = (state_q == nbr_pkg::ST_FINISH) && (!out_valid_q || out_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nbr_pkg::ST_IDLE: begin
        if (in_fire && (in_cmd == nbr_pkg::CMD_QUERY)) begin
          state_d = (brk_lim != '0) ? nbr_pkg::ST_BRK_WAIT : nbr_pkg::ST_FINISH;
        end
      end
      nbr_pkg::ST_BRK_WAIT: begin
        state_d = (rec_lim != '0) ? nbr_pkg::ST_SEARCH : nbr_pkg::ST_UPDATE;
      end
      nbr_pkg::ST_SEARCH: begin
        if (cmp_eq) begin
          state_d = nbr_pkg::ST_EVAL;
        end else if (search_go) begin
          state_d = nbr_pkg::ST_SEARCH;
        end else if (lo_nx != '0) begin
          state_d = nbr_pkg::ST_REC_WAIT;
        end else begin
          state_d = nbr_pkg::ST_UPDATE;
        end
      end
      nbr_pkg::ST_REC_WAIT: state_d = nbr_pkg::ST_EVAL;
      nbr_pkg::ST_EVAL:     state_d = nbr_pkg::ST_UPDATE;
      nbr_pkg::ST_UPDATE: begin
        state_d = (i_nx < brk_lim) ? nbr_pkg::ST_BRK_WAIT : nbr_pkg::ST_FINISH;
      end
      nbr_pkg::ST_FINISH: begin
        if (out_load) begin
          state_d = nbr_pkg::ST_IDLE;
        end
      end
      default: state_d = nbr_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rec_we     = 1'b0;
    brk_we     = 1'b0;
    rec_re     = 1'b0;
    rec_raddr  = mid_nx[REC_AW-1:0];
    brk_re     = 1'b0;
    brk_raddr  = i_nx[BRK_AW-1:0];
    case (state_q)
      nbr_pkg::ST_IDLE: begin
        rec_we     = in_fire && (in_cmd == nbr_pkg::CMD_WR_REC) && slot_rec_ok;
        brk_we     = in_fire && (in_cmd == nbr_pkg::CMD_WR_BRK) && slot_brk_ok;
        brk_re     = in_fire && (in_cmd == nbr_pkg::CMD_QUERY);
        brk_raddr  = '0;
      end
      nbr_pkg::ST_BRK_WAIT: begin
        rec_re    = (rec_lim != '0);
        rec_raddr = mid_init[REC_AW-1:0];
      end
      nbr_pkg::ST_SEARCH: begin
        if (!cmp_eq) begin
          if (search_go) begin
            rec_re    = 1'b1;
            rec_raddr = mid_nx[REC_AW-1:0];
          end else begin
            rec_re    = (lo_nx != '0);
            rec_raddr = lo_m1[REC_AW-1:0];
          end
        end
      end
      nbr_pkg::ST_UPDATE: begin
        brk_re = (i_nx < brk_lim);
      end
      default: begin
      end
    endcase
  end

  assign rec_waddr      = in_i.slot[REC_AW-1:0];
  assign brk_waddr      = in_i.slot[BRK_AW-1:0];
  assign rec_wdata.addr = in_i.code_address;
  assign rec_wdata.line = in_i.src_line;
  assign rec_wdata.col  = in_i.src_col;

  // datapath
  always_comb begin
    i_d           = i_q;
    lo_d          = lo_q;
    hip1_d        = hip1_q;
    mid_d         = mid_q;
    ip_d          = ip_q;
    qline_d       = qline_q;
    qcol_d        = qcol_q;
    rline_d       = rline_q;
    rcol_d        = rcol_q;
    cand_d        = cand_q;
    score_d       = score_q;
    best_score_d  = best_score_q;
    best_d        = best_q;
    found_d       = found_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_best_d    = out_best_q;
    out_matched_d = out_matched_q;
    case (state_q)
      nbr_pkg::ST_IDLE: begin
        if (in_fire && (in_cmd == nbr_pkg::CMD_QUERY)) begin
          qline_d = in_i.src_line;
          qcol_d  = in_i.src_col;
          i_d     = '0;
          best_d  = '0;
          found_d = 1'b0;
        end
      end
      nbr_pkg::ST_BRK_WAIT: begin
        ip_d   = brk_rdata;
        lo_d   = '0;
        hip1_d = rec_lim;
        mid_d  = mid_init;
        cand_d = 1'b0;
        // the first list entry is the fallback answer
        if (i_q == '0) begin
          best_d = brk_rdata;
        end
      end
      nbr_pkg::ST_SEARCH: begin
        if (cmp_eq) begin
          rline_d = rec_rdata.line;
          rcol_d  = rec_rdata.col;
        end else begin
          lo_d   = lo_nx;
          hip1_d = hip1_nx;
          mid_d  = mid_nx;
        end
      end
      nbr_pkg::ST_REC_WAIT: begin
        rline_d = rec_rdata.line;
        rcol_d  = rec_rdata.col;
      end
      nbr_pkg::ST_EVAL: begin
        cand_d  = at_or_after;
        score_d = score_calc;
      end
      nbr_pkg::ST_UPDATE: begin
        if (better) begin
          best_score_d = score_q;
          best_d       = ip_q;
          found_d      = 1'b1;
        end
        i_d = i_nx;
      end
      nbr_pkg::ST_FINISH: begin
        if (out_load) begin
          out_valid_d   = 1'b1;
          out_best_d    = best_q;
          out_matched_d = found_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbr_pkg::ST_IDLE;
      rec_cnt_q   <= '0;
      brk_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (nbr_pkg::reg_idx_e'(cfg_idx_i))
          nbr_pkg::REG_RECORD_COUNT:    rec_cnt_q <= cfg_data_i;
          nbr_pkg::REG_BREAKABLE_COUNT: brk_cnt_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q           <= i_d;
    lo_q          <= lo_d;
    hip1_q        <= hip1_d;
    mid_q         <= mid_d;
    ip_q          <= ip_d;
    qline_q       <= qline_d;
    qcol_q        <= qcol_d;
    rline_q       <= rline_d;
    rcol_q        <= rcol_d;
    cand_q        <= cand_d;
    score_q       <= score_d;
    best_score_q  <= best_score_d;
    best_q        <= best_d;
    found_q       <= found_d;
    out_best_q    <= out_best_d;
    out_matched_q <= out_matched_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.best_address = out_best_q;
  assign out_o.matched      = out_matched_q;

  nbr_ram #(
    .WIDTH (nbr_pkg::REC_W),
    .DEPTH (TAB_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  nbr_ram #(
    .WIDTH (nbr_pkg::ADDR_W),
    .DEPTH (BRK_DEPTH)
  ) u_brk_ram (
    .clk_i   (clk_i),
    .we_i    (brk_we),
    .waddr_i (brk_waddr),
    .wdata_i (in_i.code_address),
    .re_i    (brk_re),
    .raddr_i (brk_raddr),
    .rdata_o (brk_rdata)
  );

endmodule

// ----- hw/rtl/nbr_checker.sv -----
`timescale 1ns / 1ps
`include "nearest_breakpoint_resolver_macros.svh"

module nbr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [nbr_pkg::CMD_W-1:0]  in_cmd_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [nbr_pkg::ADDR_W-1:0] out_best_address_i,
  input logic                       out_matched_i
);

  logic wr_fire, query_fire;

  assign wr_fire    = in_valid_i && in_ready_i && (in_cmd_i != nbr_pkg::CMD_QUERY);
  assign query_fire = in_valid_i && in_ready_i && (in_cmd_i == nbr_pkg::CMD_QUERY);

  // a stalled result word holds
  `NBR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_best_address_i) && $stable(out_matched_i))

  // write words keep the input open
  `NBR_ASSERT_NEXT(a_write_one_cycle, clk_i, rst_ni, wr_fire, in_ready_i)

  // a query keeps the input closed while it runs
  `NBR_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_fire, !in_ready_i)

  // a new result appears together with the input opening again
  `NBR_ASSERT_NOW(a_result_reopens, clk_i, rst_ni, $rose(out_valid_i), in_ready_i)

endmodule

bind nearest_breakpoint_resolver nbr_checker u_nbr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .in_cmd_i           (in_i.cmd),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_best_address_i (out_o.best_address),
  .out_matched_i      (out_o.matched)
);

// ----- dv/nearest_breakpoint_resolver_tb.sv -----
`timescale 1ns / 1ps

module nearest_breakpoint_resolver_tb;
  import nbr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  localparam int unsigned RANDOM_WORDS     = 250;
  localparam int unsigned SENDER_GAP_MAX   = 6;
  localparam int unsigned LONG_HOLD_CYCLES = 1500;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned DRAIN_LIMIT      = 20000;
  localparam int unsigned TAIL_CYCLES      = 64;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              matched;
  } stop_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nbr_in_if  in_if ();
  nbr_out_if out_if ();

  nearest_breakpoint_resolver i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // own copy of the block state
  rec_t              line_table [SLOT_DEPTH];
  logic [ADDR_W-1:0] stop_list  [SLOT_DEPTH];
  logic [CNT_W-1:0]  rec_count_reg;
  logic [CNT_W-1:0]  brk_count_reg;

  stop_t stops_due [$];

  int  mismatch_count;
  int  words_sent;
  int  queries_sent;
  int  results_seen;
  int  matched_seen;
  int  burst_left;
  int  gap_max;
  bit  long_hold_armed;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", stops_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_word_t word_of(input logic [CMD_W-1:0] cmd,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [LINE_W-1:0] line,
                                       input logic [COL_W-1:0] col);
    in_word_t w;
    w.cmd  = cmd;
    w.slot = slot;
    w.addr = addr;
    w.line = line;
    w.col  = col;
    return w;
  endfunction

  // greatest record index whose address is not above addr, -1 if none
  function automatic int floor_record(input logic [ADDR_W-1:0] addr);
    int n, lo, hi, mid;
    n  = (rec_count_reg > MAX_RECORDS_DEF) ? MAX_RECORDS_DEF : rec_count_reg;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (line_table[mid].addr == addr) return mid;
      if (line_table[mid].addr < addr) lo = mid + 1;
      else hi = mid - 1;
    end
    return (lo > 0) ? lo - 1 : -1;
  endfunction

  function automatic stop_t nearest_stop(input logic [LINE_W-1:0] line,
                                         input logic [COL_W-1:0] col);
    stop_t       res;
    rec_t        rec;
    int          n, r, i;
    int unsigned best_score, score, dl, dc;
    n = (brk_count_reg > MAX_BREAKABLE_DEF) ? MAX_BREAKABLE_DEF : brk_count_reg;
    res.addr    = (n > 0) ? stop_list[0] : '0;
    res.matched = 1'b0;
    best_score  = '1;
    for (i = 0; i < n; i++) begin
      r = floor_record(stop_list[i]);
      if (r < 0) continue;
      rec = line_table[r];
      if (rec.line < line || (rec.line == line && rec.col < col)) continue;
      dl    = rec.line - line;
      dc    = (dl == 0) ? rec.col - col : 0;
      score = dl * LINE_WEIGHT + dc;
      // strict compare keeps the earliest entry on a tie
      if (score < best_score) begin
        best_score  = score;
        res.addr    = stop_list[i];
        res.matched = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void apply_word(input in_word_t w);
    case (w.cmd)
      CMD_WR_REC: line_table[w.slot] = '{addr: w.addr, line: w.line, col: w.col};
      CMD_WR_BRK: stop_list[w.slot] = w.addr;
      CMD_QUERY: begin
        stops_due.push_back(nearest_stop(w.line, w.col));
        queries_sent++;
      end
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %0s mismatch, expected %h, got %h", $realtime, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    stop_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (out_if.matched === 1'b1) matched_seen++;
      if (stops_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_if.best_address);
      end else begin
        want = stops_due.pop_front();
        if (out_if.best_address !== want.addr) begin
          flag_mismatch("best_address", want.addr, out_if.best_address);
        end
        if (out_if.matched !== want.matched) begin
          flag_mismatch("matched", {31'd0, want.matched}, {31'd0, out_if.matched});
        end
      end
    end
  end

  // result side: stall patterns that change every stretch, plus one long hold on request
  initial begin : result_receiver
    int stretch, mode;
    out_if.ready <= 1'b0;
    stretch = 0;
    mode    = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      if (stretch == 0) begin
        mode    = $urandom_range(0, 3);
        stretch = $urandom_range(20, 150);
      end
      stretch--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic push_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.cmd          <= w.cmd;
    in_if.slot         <= w.slot;
    in_if.code_address <= w.addr;
    in_if.src_line     <= w.line;
    in_if.src_col      <= w.col;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    apply_word(w);
    if (w.cmd != CMD_UNKNOWN) words_sent++;
  endtask

  // wait for every result, then let a trailing write finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (stops_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input int unsigned records, input int unsigned breakables);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RECORD_COUNT;
    cfg_data_i <= CFG_DATA_W'(records);
    @(posedge clk_i);
    cfg_idx_i  <= REG_BREAKABLE_COUNT;
    cfg_data_i <= CFG_DATA_W'(breakables);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rec_count_reg = CNT_W'(records);
    brk_count_reg = CNT_W'(breakables);
  endtask

  function automatic logic [ADDR_W-1:0] pick_stop(input int rlim);
    int k, roll;
    roll = $urandom_range(0, 99);
    if (rlim == 0 || roll >= 90) return $urandom;
    k = $urandom_range(0, rlim - 1);
    if (roll < 50) return line_table[k].addr;
    if (roll < 80) return line_table[k].addr + $urandom_range(1, 16);
    // below the first record, so no record covers it
    return line_table[0].addr - $urandom_range(1, 16);
  endfunction

  function automatic in_word_t make_query(input int rlim);
    in_word_t w;
    int       k, line, col;
    w = word_of(CMD_QUERY, SLOT_W'($urandom), $urandom, LINE_W'($urandom), COL_W'($urandom));
    if (rlim > 0 && $urandom_range(0, 4) != 0) begin
      k    = $urandom_range(0, rlim - 1);
      line = int'(line_table[k].line) - int'($urandom_range(0, 2));
      if (line < 0) line = 0;
      col = $urandom_range(0, int'(line_table[k].col) + 4);
      if (col > 65535) col = 65535;
      w.line = LINE_W'(line);
      w.col  = COL_W'(col);
    end
    return w;
  endfunction

  task automatic lay_out_records(input int count, input bit scrambled);
    logic [ADDR_W-1:0] addr;
    int                k, line, col;
    addr = $urandom_range(0, 32'h0FFF_FFFF);
    line = ($urandom_range(0, 7) == 0) ? $urandom_range(60000, 65000) : $urandom_range(0, 2000);
    for (k = 0; k < count; k++) begin
      addr = scrambled ? $urandom : addr + $urandom_range(1, 512);
      line += $urandom_range(0, 3);
      if (line > 65535) line = 65535;
      col = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 60);
      push_word(word_of(CMD_WR_REC, SLOT_W'(k), addr, LINE_W'(line), COL_W'(col)));
    end
  endtask

  task automatic lay_out_breakables(input int count, input int rlim);
    int k;
    for (k = 0; k < count; k++) begin
      push_word(word_of(CMD_WR_BRK, SLOT_W'(k), pick_stop(rlim),
                        LINE_W'($urandom), COL_W'($urandom)));
    end
  endtask

  task automatic test_reset_state();
    push_word(word_of(CMD_QUERY, 8'h00, 32'h0000_0000, 16'h0000, 16'h0000));
    push_word(word_of(CMD_QUERY, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    push_word(word_of(CMD_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_directed_cases();
    settle();
    write_regs(4, 4);
    push_word(word_of(CMD_WR_REC, 8'd0, 32'h0000_1000, 16'd10, 16'd5));
    push_word(word_of(CMD_WR_REC, 8'd1, 32'h0000_2000, 16'd10, 16'd20));
    push_word(word_of(CMD_WR_REC, 8'd2, 32'h0000_3000, 16'd12, 16'd0));
    push_word(word_of(CMD_WR_REC, 8'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    // below every record, between records, exact hit, and a tie with the second
    push_word(word_of(CMD_WR_BRK, 8'd0, 32'h0000_0000, 16'd0, 16'd0));
    push_word(word_of(CMD_WR_BRK, 8'd1, 32'h0000_2800, 16'd0, 16'd0));
    push_word(word_of(CMD_WR_BRK, 8'd2, 32'h0000_3000, 16'd0, 16'd0));
    push_word(word_of(CMD_WR_BRK, 8'd3, 32'h0000_2000, 16'd0, 16'd0));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd10, 16'd5));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd10, 16'd21));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd13, 16'd0));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd0, 16'd0));
    push_word(word_of(CMD_WR_BRK, 8'd3, 32'hFFFF_FFFF, 16'd0, 16'd0));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'hFFFF, 16'hFFFF));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'hFFFF, 16'h0000));
    // empty table: the first list entry comes back unmatched
    settle();
    write_regs(0, 2);
    push_word(word_of(CMD_WR_BRK, 8'd0, 32'h0000_1000, 16'd0, 16'd0));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd0, 16'd0));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd10, 16'd5));
  endtask

  task automatic test_full_tables();
    settle();
    // counts beyond capacity saturate
    write_regs(511, 256);
    lay_out_records(SLOT_DEPTH, 1'b0);
    lay_out_breakables(SLOT_DEPTH, SLOT_DEPTH);
    repeat (3) push_word(make_query(SLOT_DEPTH));
    settle();
    write_regs(256, 511);
    push_word(make_query(SLOT_DEPTH));
    push_word(word_of(CMD_QUERY, 8'd0, 32'd0, 16'd0, 16'd0));
  endtask

  task automatic test_random_programs();
    int first, rc, bc, rlim, blim, nq, k, roll, big_left;
    first    = words_sent;
    big_left = 3;
    while (words_sent - first < RANDOM_WORDS) begin
      settle();
      roll = $urandom_range(0, 99);
      if (roll < 8) rc = 0;
      else if (roll < 78) rc = $urandom_range(1, 16);
      else if (roll < 92) rc = $urandom_range(17, 64);
      else rc = $urandom_range(257, 511);
      roll = $urandom_range(0, 99);
      if (roll < 8) bc = 0;
      else if (roll < 80 || big_left == 0) bc = $urandom_range(1, 10);
      else if (roll < 95) bc = $urandom_range(11, 48);
      else begin
        bc = $urandom_range(200, 511);
        big_left--;
      end
      rlim = (rc > SLOT_DEPTH) ? SLOT_DEPTH : rc;
      blim = (bc > SLOT_DEPTH) ? SLOT_DEPTH : bc;
      write_regs(rc, bc);
      // large settings reuse what earlier phases left in the tables
      if (rc <= 64) lay_out_records(rc, $urandom_range(0, 9) == 0);
      if (bc <= 48) lay_out_breakables(bc, rlim);
      nq = (blim > 64) ? 3 : $urandom_range(3, 10);
      while (nq > 0) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
          push_word(word_of(CMD_UNKNOWN, SLOT_W'($urandom), $urandom,
                            LINE_W'($urandom), COL_W'($urandom)));
        end else if (roll <= 2 && blim > 0) begin
          push_word(word_of(CMD_WR_BRK, SLOT_W'($urandom_range(0, blim - 1)), pick_stop(rlim),
                            LINE_W'($urandom), COL_W'($urandom)));
        end else if (roll == 3 && rlim > 0) begin
          // same address, new start: order of the table is kept
          k = $urandom_range(0, rlim - 1);
          push_word(word_of(CMD_WR_REC, SLOT_W'(k), line_table[k].addr,
                            LINE_W'($urandom_range(0, 2000)), COL_W'($urandom_range(0, 60))));
        end else begin
          push_word(make_query(rlim));
          nq--;
        end
      end
    end
  endtask

  task automatic test_output_stall();
    settle();
    write_regs(16, 4);
    lay_out_records(16, 1'b0);
    lay_out_breakables(4, 16);
    gap_max = 0;
    long_hold_armed = 1'b1;
    repeat (24) push_word(make_query(16));
    gap_max = SENDER_GAP_MAX;
    settle();
  endtask

  task automatic finish_run();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (stops_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (stops_due.size() != 0) begin
      mismatch_count += stops_due.size();
      $display("%0d query results never arrived", stops_due.size());
    end
    $display("sent %0d words with %0d queries; %0d results checked, %0d of them matched",
             words_sent, queries_sent, results_seen, matched_seen);
    $display("counts from 0 to 511, full tables, ties, unknown commands and a long output stall");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin : test_sequence
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_RECORD_COUNT;
    cfg_data_i         <= '0;
    in_if.valid        <= 1'b0;
    in_if.cmd          <= CMD_WR_REC;
    in_if.slot         <= '0;
    in_if.code_address <= '0;
    in_if.src_line     <= '0;
    in_if.src_col      <= '0;
    rec_count_reg   = '0;
    brk_count_reg   = '0;
    mismatch_count  = 0;
    words_sent      = 0;
    queries_sent    = 0;
    results_seen    = 0;
    matched_seen    = 0;
    burst_left      = 0;
    gap_max         = SENDER_GAP_MAX;
    long_hold_armed = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_cases();
    test_full_tables();
    test_random_programs();
    test_output_stall();
    finish_run();
  end

endmodule

// ----- nearest_breakpoint_resolver.f -----
+incdir+hw/rtl
hw/rtl/nbr_pkg.sv
hw/rtl/nbr_if.sv
hw/rtl/nbr_ram.sv
hw/rtl/nearest_breakpoint_resolver.sv
hw/rtl/nbr_checker.sv
dv/nearest_breakpoint_resolver_tb.sv
